[design/sgl_pkg.sv]
// Shared types and constants for the separable Gaussian line pass.
package sgl_pkg;

  localparam int RAD_W     = 2;
  localparam int WEIGHT_W  = 16;
  localparam int CHAN_W    = 8;
  localparam int NUM_DIST  = 4;
  localparam int NUM_CHAN  = 3;
  localparam int FRAC_W    = 15;
  localparam int SUM_W     = CHAN_W + 1;
  localparam int PROD_W    = WEIGHT_W + SUM_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS        = 3'd0,
    REG_WEIGHT_CENTER = 3'd1,
    REG_WEIGHT_ONE    = 3'd2,
    REG_WEIGHT_TWO    = 3'd3,
    REG_WEIGHT_THREE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              line_end;
  } in_pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic              line_end_out;
  } out_pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [RAD_W-1:0]                   radius;
    logic [NUM_DIST-1:0][WEIGHT_W-1:0] weight;
  } cfg_t;

  // pending output: lag behind newest pixel, radius in force, flush burst
  typedef struct packed {
    logic             valid;
    logic             flush;
    logic [RAD_W-1:0] lag;
    logic [RAD_W-1:0] rad;
  } job_t;

endpackage

[design/sgl_regs.sv]
// Configuration registers: radius and the four Q1.15 tap weights.
module sgl_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sgl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgl_pkg::WEIGHT_W-1:0]     cfg_data,
  output sgl_pkg::cfg_t                    cfg
);
  import sgl_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius    <= RAD_W'(1);
      cfg.weight[0] <= 16'h8000;
      cfg.weight[1] <= '0;
      cfg.weight[2] <= '0;
      cfg.weight[3] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RADIUS:        cfg.radius    <= cfg_data[RAD_W-1:0];
        REG_WEIGHT_CENTER: cfg.weight[0] <= cfg_data;
        REG_WEIGHT_ONE:    cfg.weight[1] <= cfg_data;
        REG_WEIGHT_TWO:    cfg.weight[2] <= cfg_data;
        REG_WEIGHT_THREE:  cfg.weight[3] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[design/sgl_window.sv]
// Pixel window shift line, line position counter and output sequencer.
module sgl_window #(
  parameter  int MAX_RADIUS = 3,
  localparam int WinDepth   = 2 * MAX_RADIUS + 1,
  localparam int CntW       = $clog2(WinDepth + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sgl_pkg::in_pixel_t  in_data,
  input  sgl_pkg::cfg_t       cfg,
  input  logic                advance,
  output sgl_pkg::rgba_t      window [WinDepth],
  output sgl_pkg::job_t       job,
  output logic [CntW-1:0]     job_newest
);
  import sgl_pkg::*;

  logic [CntW-1:0]  seen;
  logic [RAD_W-1:0] rad_eff;
  logic             job_done;
  logic             ready;
  logic             accept;

  assign rad_eff  = (int'(cfg.radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : cfg.radius;
  assign job_done = !job.flush || (job.lag == '0);
  assign ready    = !job.valid || (advance && job_done);
  assign accept   = in_valid && ready;
  assign in_stall = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      job.valid <= 1'b0;
    end else if (accept) begin
      for (int i = WinDepth - 1; i > 0; i--) begin
        window[i] <= window[i-1];
      end
      window[0] <= '{red: in_data.red, green: in_data.green,
                     blue: in_data.blue, alpha: in_data.alpha};
      job_newest <= seen;
      job.rad    <= rad_eff;
      job.flush  <= in_data.line_end;
      job.valid  <= in_data.line_end || (int'(seen) >= int'(rad_eff));
      if (in_data.line_end && (int'(seen) < int'(rad_eff))) begin
        job.lag <= RAD_W'(seen);
      end else begin
        job.lag <= rad_eff;
      end
      if (in_data.line_end) begin
        seen <= '0;
      end else if (seen < CntW'(WinDepth)) begin
        seen <= CntW'(seen + 1'b1);
      end
    end else if (advance && !job_done) begin
      job.lag <= job.lag - 1'b1;
    end else if (advance && job_done) begin
      job.valid <= 1'b0;
    end
  end

endmodule

[design/sgl_kernel.sv]
// Symmetric tap filter with edge clamping, truncation and saturation.
module sgl_kernel #(
  parameter  int MAX_RADIUS = 3,
  localparam int WinDepth   = 2 * MAX_RADIUS + 1,
  localparam int CntW       = $clog2(WinDepth + 1),
  localparam int IdxW       = $clog2(WinDepth),
  localparam int PosW       = $clog2(2 * WinDepth)
) (
  input  sgl_pkg::rgba_t      window [WinDepth],
  input  sgl_pkg::job_t       job,
  input  logic [CntW-1:0]     job_newest,
  input  sgl_pkg::cfg_t       cfg,
  output sgl_pkg::out_pixel_t result
);
  import sgl_pkg::*;

  logic [NUM_CHAN-1:0][ACC_W-1:0] acc;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_out;

  always_comb begin
    logic [WEIGHT_W-1:0]             wt;
    logic [RAD_W-1:0]                lo_pos;
    logic [PosW-1:0]                 hi_pos;
    rgba_t                           lo_pix;
    rgba_t                           hi_pix;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] lo_ch;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] hi_ch;
    logic [SUM_W-1:0]                pair;
    logic [PROD_W-1:0]               prod;
    acc = '0;
    for (int j = 0; j < NUM_DIST; j++) begin
      wt = (RAD_W'(j) <= job.rad) ? cfg.weight[j] : '0;
      lo_pos = (job.lag >= RAD_W'(j)) ? RAD_W'(job.lag - RAD_W'(j)) : '0;
      hi_pos = PosW'(job.lag) + PosW'(j);
      if (hi_pos > PosW'(job_newest)) hi_pos = PosW'(job_newest);
      if (hi_pos > PosW'(WinDepth - 1)) hi_pos = PosW'(WinDepth - 1);
      lo_pix = window[IdxW'(lo_pos)];
      hi_pix = window[IdxW'(hi_pos)];
      lo_ch = {lo_pix.blue, lo_pix.green, lo_pix.red};
      hi_ch = {hi_pix.blue, hi_pix.green, hi_pix.red};
      for (int c = 0; c < NUM_CHAN; c++) begin
        if (j == 0) begin
          pair = SUM_W'(lo_ch[c]);
        end else begin
          pair = SUM_W'(lo_ch[c]) + SUM_W'(hi_ch[c]);
        end
        prod   = PROD_W'(wt) * PROD_W'(pair);
        acc[c] = acc[c] + ACC_W'(prod);
      end
    end
  end

  always_comb begin
    logic [ACC_W-FRAC_W-1:0] shifted;
    for (int c = 0; c < NUM_CHAN; c++) begin
      shifted = acc[c][ACC_W-1:FRAC_W];
      if (shifted > (ACC_W-FRAC_W)'(2**CHAN_W - 1)) begin
        chan_out[c] = '1;
      end else begin
        chan_out[c] = shifted[CHAN_W-1:0];
      end
    end
  end

  assign result.red_out      = chan_out[0];
  assign result.green_out    = chan_out[1];
  assign result.blue_out     = chan_out[2];
  assign result.alpha_out    = window[IdxW'(job.lag)].alpha;
  assign result.line_end_out = job.flush && (job.lag == '0);

endmodule

[design/separable_gaussian_line_pass.sv]
// Top level of the separable Gaussian line pass with clamp-to-edge borders.
// Pixels of one line stream in at one per clock while the output is not
// stalled and no line_end burst is draining; each blurred result is
// computed from the window and job registers, then held in the output
// register, and lags the input by radius pixels. The pixel carrying
// line_end releases every result still owed for the line, up to radius+1
// of them, one per clock from the result register while the output is not
// stalled; input is stalled until that burst is done. Radius above
// MAX_RADIUS acts as MAX_RADIUS. Weights are Q1.15; sums are truncated by
// 15 bits and saturated to 255. Alpha is copied from the centre pixel.
// Configuration writes are always ready and should be made only while no
// result is still owed or waiting at the output.
module separable_gaussian_line_pass #(
  parameter int MAX_RADIUS = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sgl_pkg::in_pixel_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sgl_pkg::out_pixel_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sgl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgl_pkg::WEIGHT_W-1:0]   cfg_data
);
  import sgl_pkg::*;

  localparam int WinDepth = 2 * MAX_RADIUS + 1;
  localparam int CntW     = $clog2(WinDepth + 1);

  cfg_t            cfg;
  rgba_t           window [WinDepth];
  job_t            job;
  logic [CntW-1:0] job_newest;
  out_pixel_t      result;
  logic            advance;

  assign advance = job.valid && (!out_valid || !out_stall);

  sgl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sgl_window #(.MAX_RADIUS(MAX_RADIUS)) u_window (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg        (cfg),
    .advance    (advance),
    .window     (window),
    .job        (job),
    .job_newest (job_newest)
  );

  sgl_kernel #(.MAX_RADIUS(MAX_RADIUS)) u_kernel (
    .window     (window),
    .job        (job),
    .job_newest (job_newest),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

[dv/separable_gaussian_line_pass_checker.sv]
// Checker for the separable Gaussian line pass: predicts each blurred pixel and compares.
`timescale 1ns / 100ps
module separable_gaussian_line_pass_checker #(
  parameter int MAX_RADIUS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  sgl_pkg::in_pixel_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  sgl_pkg::out_pixel_t           out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sgl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgl_pkg::WEIGHT_W-1:0]  cfg_data,
  output int unsigned                   errors,
  output int unsigned                   pending
);
  import sgl_pkg::*;

  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;

  rgba_t               line_win [WIN_DEPTH];
  int                  seen;
  logic [RAD_W-1:0]    radius_q;
  logic [WEIGHT_W-1:0] weight_q [NUM_DIST];
  out_pixel_t          owed_pixels [$];
  int unsigned         fail_count = 0;

  function automatic logic [CHAN_W-1:0] clip_channel(input logic [31:0] acc);
    logic [31:0] scaled;
    scaled = acc >> FRAC_W;
    return (scaled > {CHAN_W{1'b1}}) ? {CHAN_W{1'b1}} : scaled[CHAN_W-1:0];
  endfunction

  // Output lying lag places behind the newest pixel, edges replicated.
  function automatic out_pixel_t blurred_pixel(input int lag, input int newest, input int rad,
                                               input logic last);
    logic [31:0] acc_r, acc_g, acc_b;
    logic [31:0] w;
    rgba_t       tap;
    int          d, reach;
    out_pixel_t  res;
    acc_r = '0;
    acc_g = '0;
    acc_b = '0;
    for (int k = -rad; k <= rad; k++) begin
      reach = (k < 0) ? -k : k;
      w = (reach < NUM_DIST) ? 32'(weight_q[reach]) : '0;
      d = lag - k;
      if (d < 0) d = 0;
      if (d > newest) d = newest;
      if (d >= WIN_DEPTH) d = WIN_DEPTH - 1;
      tap = line_win[d];
      acc_r += w * 32'(tap.red);
      acc_g += w * 32'(tap.green);
      acc_b += w * 32'(tap.blue);
    end
    res.red_out      = clip_channel(acc_r);
    res.green_out    = clip_channel(acc_g);
    res.blue_out     = clip_channel(acc_b);
    res.alpha_out    = line_win[lag].alpha;
    res.line_end_out = last;
    return res;
  endfunction

  function automatic void accept_pixel(input in_pixel_t px);
    int rad, newest, lag;
    rad    = (radius_q > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
    newest = seen;
    for (int i = WIN_DEPTH - 1; i > 0; i--) line_win[i] = line_win[i-1];
    line_win[0] = {px.red, px.green, px.blue, px.alpha};
    if (px.line_end) begin
      lag = (newest < rad) ? newest : rad;
      for (int l = lag; l >= 0; l--) owed_pixels.push_back(blurred_pixel(l, newest, rad, l == 0));
      seen = 0;
    end else begin
      if (newest >= rad) owed_pixels.push_back(blurred_pixel(rad, newest, rad, 1'b0));
      if (seen < WIN_DEPTH) seen++;
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_pixel_t want;
    if (rst) begin
      for (int i = 0; i < WIN_DEPTH; i++) line_win[i] = '0;
      seen        = 0;
      radius_q    = 2'd1;
      weight_q[0] = 16'h8000;
      for (int i = 1; i < NUM_DIST; i++) weight_q[i] = '0;
      owed_pixels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_pixels.size() == 0) begin
          $error("output transaction with no pixel owed");
          fail_count++;
        end else begin
          want = owed_pixels.pop_front();
          check_field("red_out", want.red_out, out_data.red_out);
          check_field("green_out", want.green_out, out_data.green_out);
          check_field("blue_out", want.blue_out, out_data.blue_out);
          check_field("alpha_out", want.alpha_out, out_data.alpha_out);
          check_field("line_end_out", want.line_end_out, out_data.line_end_out);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIUS:        radius_q    = cfg_data[RAD_W-1:0];
          REG_WEIGHT_CENTER: weight_q[0] = cfg_data;
          REG_WEIGHT_ONE:    weight_q[1] = cfg_data;
          REG_WEIGHT_TWO:    weight_q[2] = cfg_data;
          REG_WEIGHT_THREE:  weight_q[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) accept_pixel(in_data);
    end
    errors  <= fail_count;
    pending <= owed_pixels.size();
  end

endmodule

[dv/separable_gaussian_line_pass_tb.sv]
// Testbench top for the separable Gaussian line pass: stimulus, idling and verdict.
`timescale 1ns / 100ps
module separable_gaussian_line_pass_tb;
  import sgl_pkg::*;

  localparam int MAX_RADIUS    = 3;
  localparam int NUM_REGS      = 5;
  localparam int RANDOM_PIXELS = 170;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_GAP       = 5;
  localparam int UNITY         = 32768;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_pixel_t            in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_pixel_t           out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WEIGHT_W-1:0]  cfg_data  = '0;

  bit          quiet = 1'b0;
  int unsigned errors, pending;
  int unsigned cycle_count = 0;
  int unsigned pixels_sent = 0;

  always #5 clk = ~clk;

  separable_gaussian_line_pass #(.MAX_RADIUS(MAX_RADIUS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  separable_gaussian_line_pass_checker #(.MAX_RADIUS(MAX_RADIUS)) blur_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("separable_gaussian_line_pass test failed");
      $finish;
    end
  end

  // receiver back-pressure, drawn per output transaction
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_pixel(input in_pixel_t px);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  // hold off input until every owed pixel has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(input int rad, input logic [WEIGHT_W-1:0] wc, w1, w2, w3,
                             input bit stray);
    logic [WEIGHT_W-1:0] value;
    value = WEIGHT_W'($urandom);
    value[RAD_W-1:0] = RAD_W'(rad);
    write_reg(REG_RADIUS, value);
    write_reg(REG_WEIGHT_CENTER, wc);
    write_reg(REG_WEIGHT_ONE, w1);
    write_reg(REG_WEIGHT_TWO, w2);
    write_reg(REG_WEIGHT_THREE, w3);
    if (stray)
      write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)), WEIGHT_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic in_pixel_t random_pixel(input bit last);
    in_pixel_t px;
    px = in_pixel_t'({$urandom, 1'b0});
    if ($urandom_range(0, 5) == 0) begin
      px.red   = {CHAN_W{px.red[0]}};
      px.green = {CHAN_W{px.green[0]}};
      px.blue  = {CHAN_W{px.blue[0]}};
    end
    px.line_end = last;
    return px;
  endfunction

  task automatic send_line(input int len);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 19) == 0) drain();
      send_pixel(random_pixel(i == len - 1));
    end
  endtask

  task automatic random_phase();
    logic [WEIGHT_W-1:0] w [NUM_DIST];
    int unsigned left;
    int          len;
    case ($urandom_range(0, 3))
      0, 1: begin
        w[0] = WEIGHT_W'($urandom_range(0, UNITY));
        left = UNITY - w[0];
        for (int d = 1; d < NUM_DIST; d++) begin
          w[d] = WEIGHT_W'($urandom_range(0, left / 2));
          left -= 2 * w[d];
        end
      end
      2: for (int d = 0; d < NUM_DIST; d++) w[d] = WEIGHT_W'($urandom);
      default: begin
        for (int d = 0; d < NUM_DIST; d++) begin
          case ($urandom_range(0, 2))
            0:       w[d] = '0;
            1:       w[d] = WEIGHT_W'(UNITY);
            default: w[d] = '1;
          endcase
        end
      end
    endcase
    drain();
    load_config($urandom_range(0, (1 << RAD_W) - 1), w[0], w[1], w[2], w[3],
                $urandom_range(0, 2) == 0);
    quiet = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(2, 4)) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 8);
      send_line(len);
    end
  endtask

  initial begin
    int unsigned first_random;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: radius one, centre tap only
    send_pixel(in_pixel_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1});
    send_pixel(in_pixel_t'{8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
    send_pixel(in_pixel_t'{8'hAA, 8'h55, 8'hFF, 8'h00, 1'b0});
    send_pixel(in_pixel_t'{8'h55, 8'hAA, 8'h00, 8'hFF, 1'b1});

    // widest kernel, full-scale weights: saturation and a short line clamped both ways
    drain();
    load_config(3, '1, '1, '1, '1, 1'b1);
    send_pixel(in_pixel_t'{8'hFF, 8'h00, 8'h01, 8'h80, 1'b0});
    send_pixel(in_pixel_t'{8'h01, 8'h80, 8'h7F, 8'hC3, 1'b1});
    send_line(5);

    // no kernel at all, half gain
    drain();
    load_config(0, 16'h4000, '0, '0, '0, 1'b0);
    send_line(2);

    // all weights zero
    drain();
    load_config(1, '0, '0, '0, '0, 1'b0);
    send_line(2);

    // normalized radius-two kernel, input held off mid-line
    drain();
    load_config(2, 16'd12000, 16'd8000, 16'd2384, '0, 1'b0);
    for (int i = 0; i < 6; i++) begin
      if (i == 3) drain();
      send_pixel(random_pixel(i == 5));
    end

    first_random = pixels_sent;
    while (pixels_sent - first_random < RANDOM_PIXELS) random_phase();

    quiet = 1'b0;
    drain();
    if (errors == 0 && pending == 0) begin
      $display("separable_gaussian_line_pass test passed");
    end else begin
      $display("separable_gaussian_line_pass test failed");
    end
    $finish;
  end

endmodule
